[sv/edge_shrinking_box_average_macros.svh]
// ---------------------------------------------------------------------------
// edge_shrinking_box_average assertion macros
// shared property forms for the box average block
// ---------------------------------------------------------------------------
`ifndef EDGE_SHRINKING_BOX_AVERAGE_MACROS_SVH
`define EDGE_SHRINKING_BOX_AVERAGE_MACROS_SVH

// same-cycle implication, off during reset
`define ESBA_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("esba same-cycle check failed");

// next-cycle implication, off during reset
`define ESBA_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("esba next-cycle check failed");

`endif

[sv/esba_pkg.sv]
// ---------------------------------------------------------------------------
// esba_pkg
// types and fixed constants of the edge shrinking box average block
// ---------------------------------------------------------------------------
package esba_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int AVG_W        = 16;
	localparam int WIDTH_REG_W  = 6;
	localparam int LENGTH_REG_W = 11;
	localparam int CFG_ADDR_W   = 1;
	localparam int CFG_DATA_W   = 11;

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_WIDTH = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_VEC_LEN      = 1'b1;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int DIV_CYCLES         = AVG_W / DIV_BITS_PER_CYCLE;
	localparam int DIV_STEP_W         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	typedef struct packed {
		logic [WIDTH_REG_W-1:0]  window_width;
		logic [LENGTH_REG_W-1:0] vec_len;
	} cfg_t;

endpackage

[sv/esba_cfg.sv]
// ---------------------------------------------------------------------------
// esba_cfg
// configuration register file, write only
// ---------------------------------------------------------------------------
module esba_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [esba_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [esba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output esba_pkg::cfg_t                    cfg
);
	import esba_pkg::*;

	logic [WIDTH_REG_W-1:0]  window_width_q;
	logic [LENGTH_REG_W-1:0] vec_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q <= WIDTH_REG_W'(1);
			vec_len_q      <= LENGTH_REG_W'(64);
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_WINDOW_WIDTH: begin
					window_width_q <= cfg_wdata[WIDTH_REG_W-1:0];
				end
				REG_VEC_LEN: begin
					vec_len_q <= cfg_wdata[LENGTH_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.window_width = window_width_q;
	assign cfg.vec_len      = vec_len_q;

endmodule

[sv/esba_mem.sv]
// ---------------------------------------------------------------------------
// esba_mem
// recent sample store, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module esba_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                            clk,
	input  logic                            wen,
	input  logic [AW-1:0]                   waddr,
	input  logic [esba_pkg::SAMPLE_W-1:0]   wdata,
	input  logic [AW-1:0]                   raddr,
	output logic [esba_pkg::SAMPLE_W-1:0]   rdata
);
	import esba_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// read-first: a read and write of the same entry returns the old word
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/esba_div.sv]
// ---------------------------------------------------------------------------
// esba_div
// radix-4 restoring divider, window sum by window count
// ---------------------------------------------------------------------------
module esba_div #(
	parameter int CNT_W = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [esba_pkg::AVG_W+CNT_W-1:0]       dividend,
	input  logic [CNT_W-1:0]                       divisor,
	output logic                                   busy,
	output logic [esba_pkg::AVG_W-1:0]             quotient
);
	import esba_pkg::*;

	localparam int SUM_W = AVG_W + CNT_W;

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      rem_q;
	logic [AVG_W-1:0]      low_q;
	logic [CNT_W-1:0]      dvs_q;
	logic                  zero_q;
	logic [CNT_W-1:0]      rem_c;
	logic [AVG_W-1:0]      low_c;

	// the mean fits in AVG_W bits, so the upper dividend bits start as remainder
	always_comb begin
		logic [CNT_W:0] t;
		rem_c = rem_q;
		low_c = low_q;
		for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
			t     = {rem_c, low_c[AVG_W-1]};
			low_c = {low_c[AVG_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t        = t - {1'b0, dvs_q};
				low_c[0] = 1'b1;
			end
			rem_c = t[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + DIV_STEP_W'(1);
			if (step_q == DIV_STEP_W'(DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[SUM_W-1:AVG_W];
			low_q  <= dividend[AVG_W-1:0];
			dvs_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= rem_c;
			low_q <= low_c;
		end
	end

	assign busy     = busy_q;
	assign quotient = zero_q ? '0 : low_q;

endmodule

[sv/edge_shrinking_box_average.sv]
// ---------------------------------------------------------------------------
// edge_shrinking_box_average
// centered box average over a sample vector, window shrinks at both ends
// ---------------------------------------------------------------------------
// One sample word is taken at a time. The first (w+2)/2-1 samples of a vector only
// fill the window; every other sample is accepted, the running sum is updated (less
// the oldest sample, read from the sample memory, once the window is full), divided
// by the count in the radix-4 divider and loaded into the output register once that
// register is free. The last sample of a vector is followed by (w+2)/2-1 drain words,
// each with a sample memory read in place of the accept. Width and length are sampled
// at the first sample of each vector; the sample memory needs no clearing pass after
// reset. tlast marks the final average of each vector.
`include "edge_shrinking_box_average_macros.svh"

module edge_shrinking_box_average #(
	parameter int MAX_WINDOW = 32,
	parameter int MAX_LENGTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [esba_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [esba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [15:0] sample
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [15:0]                       m_axis_tdata,  // [15:0] average
	output logic                              m_axis_tlast   // vector_done
);
	import esba_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_LENGTH + 1);
	localparam int POS_W = $clog2(MAX_LENGTH);
	localparam int CW    = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_DIV,
		S_DRD,
		S_DSUB
	} state_t;

	cfg_t                cfg;
	state_t              state_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [POS_W-1:0]    pos_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rp_q;
	logic [CNT_W-1:0]    act_w_q;
	logic [CNT_W-1:0]    act_h_q;
	logic [LEN_W-1:0]    act_l_q;
	logic                last_q;
	logic [CNT_W-1:0]    drain_q;
	logic                m_tvalid_q;
	logic [AVG_W-1:0]    m_tdata_q;
	logic                m_tlast_q;

	logic [SAMPLE_W-1:0] mem_rdata;
	logic                s_accept;
	logic [AW-1:0]       wp_inc;
	logic [AW-1:0]       rp_inc;
	logic [CW-1:0]       len_c;
	logic [CW-1:0]       w_c;
	logic [CW-1:0]       h_c;
	logic [CW-1:0]       pe;
	logic [CW-1:0]       p1;
	logic                fill;
	logic                in_grow;
	logic                last_pos;
	logic [SUM_W-1:0]    sum_n;
	logic [CNT_W-1:0]    cnt_n;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [AVG_W-1:0]    div_quot;
	logic                out_free;
	logic                out_load;
	logic                vec_start;
	logic                vec_clean;
	logic                final_load;
	logic                final_out;

	esba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	esba_mem #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.wen   (s_accept),
		.waddr (wp_q),
		.wdata (s_axis_tdata),
		.raddr (rp_q),
		.rdata (mem_rdata)
	);

	esba_div #(
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_n),
		.divisor  (cnt_n),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign div_done      = !div_busy;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign out_load      = (state_q == S_DIV) && div_done && out_free;

	assign wp_inc = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
	assign rp_inc = (rp_q == AW'(MAX_WINDOW - 1)) ? '0 : rp_q + AW'(1);

	// effective width, half width and length for a vector about to start
	always_comb begin
		logic [CW-1:0] vl;
		logic [CW-1:0] ww;
		logic [CW-1:0] w1;
		logic [CW-1:0] w2;
		vl = CW'(cfg.vec_len);
		ww = CW'(cfg.window_width);
		if (vl == '0) begin
			len_c = CW'(1);
		end else if (vl > CW'(MAX_LENGTH)) begin
			len_c = CW'(MAX_LENGTH);
		end else begin
			len_c = vl;
		end
		w1  = (ww == '0) ? CW'(1) : ww;
		w2  = (w1 > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : w1;
		w_c = (w2 > len_c) ? len_c : w2;
		h_c = (w_c + CW'(2)) >> 1;
	end

	always_comb begin
		pe       = CW'(pos_q);
		p1       = pe + CW'(1);
		fill     = p1 < CW'(act_h_q);
		in_grow  = pe < CW'(act_w_q);
		last_pos = p1 >= CW'(act_l_q);
		if (state_q == S_DSUB) begin
			sum_n = sum_q - SUM_W'(mem_rdata);
			cnt_n = cnt_q - CNT_W'(cnt_q != '0);
		end else if (in_grow) begin
			sum_n = sum_q + SUM_W'(sample_s1);
			cnt_n = cnt_q + CNT_W'(1);
		end else begin
			// oldest sample leaves as the new one comes in
			sum_n = sum_q + SUM_W'(sample_s1) - SUM_W'(mem_rdata);
			cnt_n = cnt_q;
		end
		div_start = ((state_q == S_UPD) && !fill) || (state_q == S_DSUB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sample_s1  <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			pos_q      <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
			act_w_q    <= CNT_W'(1);
			act_h_q    <= CNT_W'(1);
			act_l_q    <= LEN_W'(1);
			last_q     <= 1'b0;
			drain_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_axis_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						sample_s1 <= s_axis_tdata;
						if (pos_q == '0) begin
							act_w_q <= w_c[CNT_W-1:0];
							act_h_q <= h_c[CNT_W-1:0];
							act_l_q <= len_c[LEN_W-1:0];
						end
						wp_q    <= wp_inc;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					if (!in_grow) begin
						rp_q <= rp_inc;
					end
					pos_q   <= last_pos ? '0 : p1[POS_W-1:0];
					last_q  <= last_pos;
					drain_q <= last_pos ? act_h_q - CNT_W'(1) : '0;
					state_q <= fill ? S_IDLE : S_DIV;
				end
				S_DIV: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= div_quot;
						m_tlast_q  <= last_q && (drain_q == '0);
						if (drain_q != '0) begin
							state_q <= S_DRD;
						end else begin
							state_q <= S_IDLE;
							if (last_q) begin
								// vector finished, start the next one clean
								sum_q  <= '0;
								cnt_q  <= '0;
								wp_q   <= '0;
								rp_q   <= '0;
								last_q <= 1'b0;
							end
						end
					end
				end
				S_DRD: begin
					rp_q    <= rp_inc;
					state_q <= S_DSUB;
				end
				S_DSUB: begin
					sum_q   <= sum_n;
					cnt_q   <= cnt_n;
					drain_q <= drain_q - CNT_W'(1);
					state_q <= S_DIV;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

	assign vec_start  = (state_q == S_IDLE) && (pos_q == '0);
	assign vec_clean  = (sum_q == '0) && (cnt_q == '0) && (wp_q == '0) && (rp_q == '0);
	assign final_load = out_load && last_q && (drain_q == '0);
	assign final_out  = (state_q == S_IDLE) && m_tvalid_q && m_tlast_q;

	`ESBA_ASSERT_IMP(a_cnt_within_width, clk, arst_n, state_q != S_IDLE, cnt_q <= act_w_q)
	`ESBA_ASSERT_IMP(a_clean_vector_start, clk, arst_n, vec_start, vec_clean)
	`ESBA_ASSERT_NXT(a_final_word_marked, clk, arst_n, final_load, final_out)

endmodule
